[design/spq_pkg.sv]
// shared types and codes for the sorted priority queue
// no dependencies; used by every module of the block and by the checker
package spq_pkg;

    localparam int TAG_WIDTH = 8;

    // request kind carried in the input tuser
    typedef enum logic [0:0] {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req;

    // result status carried in the output tuser
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_op;

endpackage

[design/spq_cell.sv]
// one slot of the sorted row: holds an entry and moves it to a neighbor
// depends on spq_pkg (cell command struct, tag width)
module spq_cell #(
    parameter int DATA_WIDTH = 16,
    parameter int PRIO_WIDTH = 5
) (
    input  logic                          i_clk,
    input  spq_pkg::t_cell_op             i_op,
    input  logic                          i_occupied,
    input  logic                          i_prev_ge,
    input  logic [DATA_WIDTH-1:0]         i_new_value,
    input  logic [PRIO_WIDTH-1:0]         i_new_prio,
    input  logic [spq_pkg::TAG_WIDTH-1:0] i_new_tag,
    input  logic [DATA_WIDTH-1:0]         i_lower_value,
    input  logic [PRIO_WIDTH-1:0]         i_lower_prio,
    input  logic [spq_pkg::TAG_WIDTH-1:0] i_lower_tag,
    input  logic [DATA_WIDTH-1:0]         i_upper_value,
    input  logic [PRIO_WIDTH-1:0]         i_upper_prio,
    input  logic [spq_pkg::TAG_WIDTH-1:0] i_upper_tag,
    output logic                          o_ge,
    output logic [DATA_WIDTH-1:0]         o_value,
    output logic [PRIO_WIDTH-1:0]         o_prio,
    output logic [spq_pkg::TAG_WIDTH-1:0] o_tag,
    output logic [DATA_WIDTH-1:0]         o_next_value
);

    logic [DATA_WIDTH-1:0]         r_value, n_value;
    logic [PRIO_WIDTH-1:0]         r_prio,  n_prio;
    logic [spq_pkg::TAG_WIDTH-1:0] r_tag,   n_tag;

    // empty slot or stored priority not below the new one
    assign o_ge = !i_occupied || (r_prio >= i_new_prio);

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        n_tag   = r_tag;
        if (i_op.insert) begin
            if (o_ge && !i_prev_ge) begin
                n_value = i_new_value;
                n_prio  = i_new_prio;
                n_tag   = i_new_tag;
            end else if (i_prev_ge) begin
                n_value = i_lower_value;
                n_prio  = i_lower_prio;
                n_tag   = i_lower_tag;
            end
        end else if (i_op.remove) begin
            n_value = i_upper_value;
            n_prio  = i_upper_prio;
            n_tag   = i_upper_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
        r_tag   <= n_tag;
    end

    assign o_value      = r_value;
    assign o_prio       = r_prio;
    assign o_tag        = r_tag;
    assign o_next_value = n_value;

endmodule

[design/sorted_priority_queue_top.sv]
// top level of the sorted priority queue: request stream in, result stream out
// depends on spq_pkg and spq_cell
//
// usage
//   slave channel carries requests: tuser is the kind (insert or remove head),
//   tdata the entry to insert. master channel carries one result per request:
//   tuser is the status, tdata the removed entry, head, count and value sum.
//   entries sit in a row of DEPTH cells sorted by ascending priority number,
//   cell 0 holding the head. on insert every cell compares its priority with
//   the new one at once and the row shifts up behind the insert point; a new
//   entry lands ahead of stored entries of equal priority. removal shifts the
//   whole row down by one cell.
// throughput
//   one request per cycle while the output register is free or being taken; the
//   result is registered in the output register when the request is taken. the
//   cell row adds no stall of its own; each cell does one compare and one select per cycle.
// reset
//   i_rst_n low clears the count, the sum and the output valid; the cell
//   contents are not cleared, only cells below the count are ever read.
// stall
//   while a result waits and the receiver holds tready low, o_s_axis_tready
//   drops and the queue state holds; a taken result frees the register in the
//   same cycle, so a new request can enter while the old result leaves.
module sorted_priority_queue_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16,
    parameter int PRIO_WIDTH = 5
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // request channel
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // entry_value, entry_priority, entry_tag, zero padding
    input  logic [((DATA_WIDTH+PRIO_WIDTH+spq_pkg::TAG_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // req_type
    input  logic [0:0]              i_s_axis_tuser,
    // result channel
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // removed_value, removed_priority, removed_tag, head_valid, head_value,
    // entry_count, value_total, zero padding
    output logic [((2*DATA_WIDTH+PRIO_WIDTH+spq_pkg::TAG_WIDTH+1+$clog2(DEPTH+1)
                    +DATA_WIDTH+$clog2(DEPTH)+7)/8)*8-1:0] o_m_axis_tdata,
    // status
    output logic [1:0]              o_m_axis_tuser
);

    localparam int TW     = spq_pkg::TAG_WIDTH;
    localparam int CW     = $clog2(DEPTH + 1);      // entry count width
    localparam int SW     = DATA_WIDTH + $clog2(DEPTH); // value sum width
    localparam int OUT_W  = ((2*DATA_WIDTH + PRIO_WIDTH + TW + 1 + CW + SW + 7) / 8) * 8;

    // request fields
    logic                  w_accept;
    spq_pkg::t_req         w_req;
    logic [DATA_WIDTH-1:0] w_new_value;
    logic [PRIO_WIDTH-1:0] w_new_prio;
    logic [TW-1:0]         w_new_tag;

    assign w_req       = spq_pkg::t_req'(i_s_axis_tuser[0]);
    assign w_new_value = i_s_axis_tdata[DATA_WIDTH-1:0];
    assign w_new_prio  = i_s_axis_tdata[DATA_WIDTH+PRIO_WIDTH-1:DATA_WIDTH];
    assign w_new_tag   = i_s_axis_tdata[DATA_WIDTH+PRIO_WIDTH+TW-1:DATA_WIDTH+PRIO_WIDTH];

    // queue bookkeeping
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] r_total, n_total;
    logic          w_full, w_empty;

    // output register
    logic             r_m_valid, n_m_valid;
    logic [OUT_W-1:0] r_m_data,  n_m_data;
    logic [1:0]       r_m_user,  n_m_user;

    // the row of cells
    spq_pkg::t_cell_op     w_op;
    logic                  w_ge    [DEPTH];
    logic [DATA_WIDTH-1:0] w_value [DEPTH];
    logic [PRIO_WIDTH-1:0] w_prio  [DEPTH];
    logic [TW-1:0]         w_tag   [DEPTH];
    logic [DATA_WIDTH-1:0] w_next_value [DEPTH];

    // a new request enters whenever the output register is free or being taken
    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_op.insert = w_accept && (w_req == spq_pkg::REQ_INSERT) && !w_full;
    assign w_op.remove = w_accept && (w_req == spq_pkg::REQ_REMOVE) && !w_empty;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        localparam int LO = (gi == 0) ? 0 : gi - 1;
        localparam int HI = (gi == DEPTH - 1) ? gi : gi + 1;

        logic w_occupied;
        logic w_prev_ge;

        assign w_occupied = (CW'(gi) < r_count);
        // cell 0 has no neighbor below, so it is always the insert point when ge
        assign w_prev_ge  = (gi == 0) ? 1'b0 : w_ge[LO];

        spq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .PRIO_WIDTH (PRIO_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_op          (w_op),
            .i_occupied    (w_occupied),
            .i_prev_ge     (w_prev_ge),
            .i_new_value   (w_new_value),
            .i_new_prio    (w_new_prio),
            .i_new_tag     (w_new_tag),
            .i_lower_value (w_value[LO]),
            .i_lower_prio  (w_prio[LO]),
            .i_lower_tag   (w_tag[LO]),
            .i_upper_value (w_value[HI]),
            .i_upper_prio  (w_prio[HI]),
            .i_upper_tag   (w_tag[HI]),
            .o_ge          (w_ge[gi]),
            .o_value       (w_value[gi]),
            .o_prio        (w_prio[gi]),
            .o_tag         (w_tag[gi]),
            .o_next_value  (w_next_value[gi])
        );
    end

    // count, sum and the result word
    always_comb begin
        logic [DATA_WIDTH-1:0] v_rem_value;
        logic [PRIO_WIDTH-1:0] v_rem_prio;
        logic [TW-1:0]         v_rem_tag;
        logic [DATA_WIDTH-1:0] v_head;
        spq_pkg::t_status      v_status;

        n_count     = r_count;
        n_total     = r_total;
        v_rem_value = '0;
        v_rem_prio  = '0;
        v_rem_tag   = '0;
        v_status    = spq_pkg::ST_OK;

        if (w_op.insert) begin
            n_count = r_count + CW'(1);
            n_total = r_total + SW'(w_new_value);
        end else if (w_op.remove) begin
            n_count     = r_count - CW'(1);
            n_total     = r_total - SW'(w_value[0]);
            v_rem_value = w_value[0];
            v_rem_prio  = w_prio[0];
            v_rem_tag   = w_tag[0];
        end else if (w_req == spq_pkg::REQ_INSERT) begin
            v_status = spq_pkg::ST_OVERFLOW;
        end else begin
            v_status = spq_pkg::ST_UNDERFLOW;
        end

        v_head = (n_count != '0) ? w_next_value[0] : '0;

        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        if (w_accept) begin
            n_m_valid = 1'b1;
            n_m_data  = OUT_W'({n_total, n_count, v_head, (n_count != '0),
                                v_rem_tag, v_rem_prio, v_rem_value});
            n_m_user  = v_status;
        end else if (i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_total   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_total   <= n_total;
            r_m_valid <= n_m_valid;
        end
    end

    // result payload needs no reset
    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

endmodule

[design/spq_checker.sv]
// port-level checks for the sorted priority queue, bound to the top level
// depends on spq_pkg and sorted_priority_queue_top
module spq_checker #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16,
    parameter int PRIO_WIDTH = 5
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_axis_tvalid,
    input logic o_s_axis_tready,
    input logic [((DATA_WIDTH+PRIO_WIDTH+spq_pkg::TAG_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    input logic [0:0] i_s_axis_tuser,
    input logic o_m_axis_tvalid,
    input logic i_m_axis_tready,
    input logic [((2*DATA_WIDTH+PRIO_WIDTH+spq_pkg::TAG_WIDTH+1+$clog2(DEPTH+1)
                   +DATA_WIDTH+$clog2(DEPTH)+7)/8)*8-1:0] o_m_axis_tdata,
    input logic [1:0] o_m_axis_tuser
);

    localparam int CW     = $clog2(DEPTH + 1);
    localparam int HV_BIT = DATA_WIDTH + PRIO_WIDTH + spq_pkg::TAG_WIDTH;
    localparam int CNT_LO = HV_BIT + 1 + DATA_WIDTH;

    logic          w_head_valid;
    logic [CW-1:0] w_count;

    assign w_head_valid = o_m_axis_tdata[HV_BIT];
    assign w_count      = o_m_axis_tdata[CNT_LO+CW-1:CNT_LO];

    // a stalled result holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // head flag agrees with the count
    a_head_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_head_valid == (w_count != '0)))
        else $error("head valid disagrees with entry count");

    // overflow only reported on a full queue
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == spq_pkg::ST_OVERFLOW) |->
            (w_count == CW'(DEPTH)))
        else $error("overflow with queue not full");

    // underflow only reported on an empty queue
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == spq_pkg::ST_UNDERFLOW) |->
            (w_count == '0) && !w_head_valid)
        else $error("underflow with queue not empty");

endmodule

bind sorted_priority_queue_top spq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .PRIO_WIDTH (PRIO_WIDTH)
) u_spq_checker (.*);

[tb/sorted_priority_queue_top_test.sv]
// self-checking testbench for sorted_priority_queue_top: table-driven directed requests,
// then random request sequences, each result checked against a typed row or a shadow queue
// depends on spq_pkg and the rtl of sorted_priority_queue_top
module sorted_priority_queue_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // block configuration, matching the instance below
    localparam int DEPTH = 16;
    localparam int DW    = 16;
    localparam int PW    = 5;
    localparam int TW    = spq_pkg::TAG_WIDTH;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = DW + $clog2(DEPTH);
    localparam int IN_W  = ((DW + PW + TW + 7) / 8) * 8;
    localparam int OUT_W = ((2 * DW + PW + TW + 1 + CW + SW + 7) / 8) * 8;

    // result tdata field offsets, lowest field first
    localparam int RP_LO  = DW;
    localparam int RT_LO  = RP_LO + PW;
    localparam int HV_BIT = RT_LO + TW;
    localparam int HD_LO  = HV_BIT + 1;
    localparam int CNT_LO = HD_LO + DW;
    localparam int SUM_LO = CNT_LO + CW;

    localparam int RANDOM_REQUESTS = 525;

    typedef struct {
        spq_pkg::t_req kind;
        logic [15:0]   value;
        logic [4:0]    prio;
        logic [7:0]    tag;
    } t_request;

    typedef struct {
        spq_pkg::t_status status;
        logic [15:0]      removed_value;
        logic [4:0]       removed_prio;
        logic [7:0]       removed_tag;
        logic             head_valid;
        logic [15:0]      head_value;
        logic [4:0]       entry_count;
        logic [19:0]      value_total;
    } t_result;

    typedef struct {
        logic [15:0] value;
        logic [4:0]  prio;
        logic [7:0]  tag;
    } t_slot;

    // one row of the directed script; typed rows carry their own expected result
    typedef struct {
        t_request rq;
        bit       typed;
        t_result  want;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic            req_valid = 1'b0;
    logic [IN_W-1:0] req_data = '0;     // entry_value, entry_priority, entry_tag, zero pad
    logic [0:0]      req_kind = spq_pkg::REQ_INSERT;   // req_type
    logic            result_ready = 1'b0;

    logic             o_s_axis_tready;
    logic             o_m_axis_tvalid;
    logic [OUT_W-1:0] o_m_axis_tdata;   // removed value/prio/tag, head_valid, head_value,
                                        // entry_count, value_total, zero pad
    logic [1:0]       o_m_axis_tuser;   // status

    // shadow copy of the queue contents, kept in head-first order
    t_slot       shadow_slots[DEPTH];
    int          shadow_count = 0;
    logic [20:0] shadow_total = '0;

    t_result expected_results[$];
    int      error_count = 0;
    int      burst_left = 0;

    sorted_priority_queue_top #(
        .DEPTH     (DEPTH),
        .DATA_WIDTH(DW),
        .PRIO_WIDTH(PW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(req_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (req_data),
        .i_s_axis_tuser (req_kind),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(result_ready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // one line per failure
    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input longint got, input longint want);
        if (got != want) begin
            flag_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        end
    endtask

    // apply one request to the shadow queue and return the result it should produce
    function automatic t_result step_shadow_queue(input t_request rq);
        t_result res;
        int      pos;
        res.status        = spq_pkg::ST_OK;
        res.removed_value = '0;
        res.removed_prio  = '0;
        res.removed_tag   = '0;
        if (rq.kind == spq_pkg::REQ_INSERT) begin
            if (shadow_count >= DEPTH) begin
                // full: entry dropped, nothing changes
                res.status = spq_pkg::ST_OVERFLOW;
            end else begin
                // new entry goes ahead of the first entry with priority not below its own,
                // so it lands in front of older entries of equal priority
                pos = 0;
                while (pos < shadow_count && shadow_slots[pos].prio < rq.prio) pos++;
                for (int i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
                shadow_slots[pos] = '{value: rq.value, prio: rq.prio, tag: rq.tag};
                shadow_count++;
                shadow_total += rq.value;
            end
        end else if (shadow_count == 0) begin
            res.status = spq_pkg::ST_UNDERFLOW;
        end else begin
            res.removed_value = shadow_slots[0].value;
            res.removed_prio  = shadow_slots[0].prio;
            res.removed_tag   = shadow_slots[0].tag;
            for (int i = 0; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i+1];
            shadow_count--;
            shadow_total -= res.removed_value;
        end
        res.head_valid  = (shadow_count != 0);
        res.head_value  = (shadow_count != 0) ? shadow_slots[0].value : 16'h0;
        res.entry_count = 5'(shadow_count);
        res.value_total = shadow_total[19:0];
        return res;
    endfunction

    // expected result for rows whose outcome is obvious: nothing removed
    function automatic t_result obvious_result(input spq_pkg::t_status st, input logic hv,
                                               input logic [15:0] head, input logic [4:0] cnt,
                                               input logic [19:0] total);
        t_result res;
        res.status        = st;
        res.removed_value = '0;
        res.removed_prio  = '0;
        res.removed_tag   = '0;
        res.head_valid    = hv;
        res.head_value    = head;
        res.entry_count   = cnt;
        res.value_total   = total;
        return res;
    endfunction

    function automatic t_script_row insert_row(input logic [15:0] value, input logic [4:0] prio,
                                               input logic [7:0] tag);
        t_script_row row;
        row.rq    = '{kind: spq_pkg::REQ_INSERT, value: value, prio: prio, tag: tag};
        row.typed = 1'b0;
        row.want  = obvious_result(spq_pkg::ST_OK, 1'b0, '0, '0, '0);
        return row;
    endfunction

    // drive one request, wait for its handshake, record the expected result, then
    // idle for a random gap once the current burst runs out
    task automatic send_request(input t_request rq, input bit typed, input t_result want);
        t_result predicted;
        int      gap;
        @(negedge i_clk);
        req_valid <= 1'b1;
        req_data  <= IN_W'({rq.tag, rq.prio, rq.value});
        req_kind  <= rq.kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = step_shadow_queue(rq);
        expected_results.push_back(typed ? want : predicted);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(0, 40);
            if (gap > 0) begin
                @(negedge i_clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // stop sending until every outstanding result has come back
    task automatic drain_results();
        @(negedge i_clk);
        req_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // result receiver: phases of full speed, light, heavy and sparse acceptance
    initial begin
        int mode;
        int run;
        forever begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(5, 40);
            repeat (run) begin
                @(negedge i_clk);
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= ($urandom_range(0, 3) != 0);
                    2:       result_ready <= 1'($urandom_range(0, 1));
                    default: result_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && result_ready) begin
            got.status        = spq_pkg::t_status'(o_m_axis_tuser);
            got.removed_value = o_m_axis_tdata[DW-1:0];
            got.removed_prio  = o_m_axis_tdata[RT_LO-1:RP_LO];
            got.removed_tag   = o_m_axis_tdata[HV_BIT-1:RT_LO];
            got.head_valid    = o_m_axis_tdata[HV_BIT];
            got.head_value    = o_m_axis_tdata[CNT_LO-1:HD_LO];
            got.entry_count   = o_m_axis_tdata[SUM_LO-1:CNT_LO];
            got.value_total   = o_m_axis_tdata[SUM_LO+SW-1:SUM_LO];
            if (expected_results.size() == 0) begin
                flag_error("result arrived with no request outstanding");
            end else begin
                want = expected_results.pop_front();
                compare_field("status", got.status, want.status);
                compare_field("removed_value", got.removed_value, want.removed_value);
                compare_field("removed_priority", got.removed_prio, want.removed_prio);
                compare_field("removed_tag", got.removed_tag, want.removed_tag);
                compare_field("head_valid", got.head_valid, want.head_valid);
                compare_field("head_value", got.head_value, want.head_value);
                compare_field("entry_count", got.entry_count, want.entry_count);
                compare_field("value_total", got.value_total, want.value_total);
            end
        end
    end

    // main sequence
    initial begin
        t_script_row script[$];
        t_script_row row;
        t_request    rq;
        t_result     none;
        int          issued;
        int          seg_len;
        int          insert_pct;
        int          prio_mode;
        logic [4:0]  seg_prio;
        bit          paused;

        none = obvious_result(spq_pkg::ST_OK, 1'b0, '0, '0, '0);

        // hold the synchronous reset, then release it
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed script
        // remove from an empty queue: underflow, everything zero
        row.rq    = '{kind: spq_pkg::REQ_REMOVE, value: 16'hA5A5, prio: 5'h1F, tag: 8'h5A};
        row.typed = 1'b1;
        row.want  = obvious_result(spq_pkg::ST_UNDERFLOW, 1'b0, 16'h0, 5'd0, 20'h0);
        script.push_back(row);
        // first insert with every field at its top value
        row = insert_row(16'hFFFF, 5'd31, 8'hFF);
        row.typed = 1'b1;
        row.want  = obvious_result(spq_pkg::ST_OK, 1'b1, 16'hFFFF, 5'd1, 20'h0FFFF);
        script.push_back(row);
        // fill to the brim with top values; ties at 0, 7, 15 and 31 check newer-first order
        script.push_back(insert_row(16'hFFFF, 5'd0, 8'h01));
        script.push_back(insert_row(16'hFFFF, 5'd0, 8'h02));
        script.push_back(insert_row(16'hFFFF, 5'd31, 8'h03));
        script.push_back(insert_row(16'hFFFF, 5'd15, 8'h04));
        script.push_back(insert_row(16'hFFFF, 5'd15, 8'h05));
        script.push_back(insert_row(16'hFFFF, 5'd16, 8'h06));
        script.push_back(insert_row(16'hFFFF, 5'd1, 8'h07));
        script.push_back(insert_row(16'hFFFF, 5'd30, 8'h08));
        script.push_back(insert_row(16'hFFFF, 5'd0, 8'h09));
        script.push_back(insert_row(16'hFFFF, 5'd7, 8'h0A));
        script.push_back(insert_row(16'hFFFF, 5'd7, 8'h0B));
        script.push_back(insert_row(16'hFFFF, 5'd7, 8'h0C));
        script.push_back(insert_row(16'hFFFF, 5'd31, 8'h0D));
        script.push_back(insert_row(16'hFFFF, 5'd2, 8'h0E));
        script.push_back(insert_row(16'hFFFF, 5'd0, 8'h0F));
        // insert into a full queue: rejected, count and sum stay at their maximum
        row = insert_row(16'h0000, 5'd0, 8'h10);
        row.typed = 1'b1;
        row.want  = obvious_result(spq_pkg::ST_OVERFLOW, 1'b1, 16'hFFFF, 5'd16, 20'hFFFF0);
        script.push_back(row);
        // pull the head a few times, order comes from the shadow queue
        repeat (7) begin
            row.rq    = '{kind: spq_pkg::REQ_REMOVE, value: 16'h5A5A, prio: 5'h0A, tag: 8'hC3};
            row.typed = 1'b0;
            row.want  = none;
            script.push_back(row);
        end

        foreach (script[i]) send_request(script[i].rq, script[i].typed, script[i].want);

        // hold off until the queue has answered everything
        drain_results();

        // random part: segments that fill, drain or churn the queue, each with its own
        // priority spread so that ties and both ends of the range show up often
        issued = 0;
        paused = 1'b0;
        while (issued < RANDOM_REQUESTS) begin
            seg_len = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 50;
            endcase
            prio_mode = $urandom_range(0, 3);
            seg_prio  = 5'($urandom_range(0, 31));
            repeat (seg_len) begin
                rq.kind = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::REQ_INSERT
                                                                : spq_pkg::REQ_REMOVE;
                case ($urandom_range(0, 7))
                    0:       rq.value = 16'h0000;
                    1:       rq.value = 16'hFFFF;
                    default: rq.value = 16'($urandom_range(0, 16'hFFFF));
                endcase
                case (prio_mode)
                    0:       rq.prio = 5'($urandom_range(0, 31));
                    1:       rq.prio = 5'($urandom_range(0, 3));
                    2:       rq.prio = seg_prio;
                    default: rq.prio = $urandom_range(0, 1) ? 5'd31 : 5'd0;
                endcase
                rq.tag = 8'($urandom_range(0, 255));
                send_request(rq, 1'b0, none);
                issued++;
            end
            // one more full pause midway through
            if (!paused && issued >= RANDOM_REQUESTS / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end

        // wait for the last results, then idle to catch any stray output
        drain_results();
        repeat (5) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sorted_priority_queue_top.f]
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue_top.sv
design/spq_checker.sv
tb/sorted_priority_queue_top_test.sv
